// ----- hw/rtl/query_request_body_parser_core_assert.svh -----
// Assertion macros used by the parse stage of the query request body parser RTL.
`ifndef QUERY_REQUEST_BODY_PARSER_CORE_ASSERT_SVH
`define QUERY_REQUEST_BODY_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define QRBP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define QRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/qrbp_pkg.sv -----
// Types, codes and constants of the query request body parser.
package qrbp_pkg;

    // Parse phases; the phases below PH_DONE double as field codes.
    typedef enum logic [4:0] {
        PH_QLEN   = 5'd0,
        PH_QUERY  = 5'd1,
        PH_IDLEN  = 5'd2,
        PH_ID     = 5'd3,
        PH_CONS   = 5'd4,
        PH_FLAGS  = 5'd5,
        PH_VCOUNT = 5'd6,
        PH_NLEN   = 5'd7,
        PH_NAME   = 5'd8,
        PH_VLEN   = 5'd9,
        PH_VALUE  = 5'd10,
        PH_PAGE   = 5'd11,
        PH_PLEN   = 5'd12,
        PH_PSTATE = 5'd13,
        PH_SERIAL = 5'd14,
        PH_TS     = 5'd15,
        PH_DONE   = 5'd16,
        PH_ERR    = 5'd17
    } phase_t;

    localparam logic [4:0] CODE_IGNORED = 5'd16;

    // Request kinds.
    localparam logic [1:0] KIND_QUERY   = 2'd0;
    localparam logic [1:0] KIND_PREPARE = 2'd1;
    localparam logic [1:0] KIND_EXECUTE = 2'd2;

    // Frame status codes, also used for the sticky error record.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_BADLEN = 2'd2;
    localparam logic [1:0] ST_TRAIL  = 2'd3;

    // Flag bits of the query parameters.
    localparam int FLAG_VLIST  = 0;
    localparam int FLAG_PAGE   = 2;
    localparam int FLAG_PSTATE = 3;
    localparam int FLAG_SERIAL = 4;
    localparam int FLAG_TS     = 5;
    localparam int FLAG_NAMES  = 6;

    // One input byte with its side information.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       body_end;
        logic [1:0] request_kind;
    } in_item_t;

    // One tagged output byte.
    typedef struct packed {
        logic [4:0] field_code;
        logic [7:0] field_byte;
        logic       field_last;
        logic       frame_done;
        logic [1:0] frame_status;
    } out_item_t;

    // Phase entry: new phase and its byte count.
    typedef struct packed {
        phase_t      ph;
        logic [31:0] cnt;
    } enter_t;

endpackage

// ----- hw/rtl/qrbp_in_stage.sv -----
// Input register stage of the query request body parser.
module qrbp_in_stage
    import qrbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     advance,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    in_item_t item_reg;

    // The register takes a new transaction when empty or draining this cycle.
    assign in_ready   = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- hw/rtl/qrbp_parser.sv -----
// Parse state and per-byte field tagging of the query request body parser.
`include "query_request_body_parser_core_assert.svh"

module qrbp_parser
    import qrbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  in_item,
    output out_item_t res
);

    phase_t      phase_reg, phase_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] acc_reg, acc_next;
    logic [6:0]  flags_reg, flags_next;
    logic [15:0] vals_reg, vals_next;
    logic [1:0]  err_reg, err_next;
    logic        start_reg, start_next;
    logic [1:0]  kind_reg, kind_next;

    // Working copies after the body-start override.
    phase_t      ph;
    logic [31:0] left_cur;
    logic [31:0] acc_cur;
    logic [31:0] acc_sh;
    logic [31:0] left_dec;
    logic [15:0] vals_dec;
    logic [15:0] vcount;
    logic [6:0]  new_flags;
    enter_t      ent;
    logic        do_enter;

    function automatic enter_t mk(input phase_t p, input logic [31:0] n);
        enter_t e;
        e.ph  = p;
        e.cnt = n;
        return e;
    endfunction

    // First optional part at or after position k that its flag selects.
    function automatic enter_t advance_opt(input logic [2:0] k, input logic [6:0] f);
        enter_t e;
        priority if (k <= 3'd0 && f[FLAG_VLIST]) e = mk(PH_VCOUNT, 32'd2);
        else if (k <= 3'd1 && f[FLAG_PAGE])       e = mk(PH_PAGE, 32'd4);
        else if (k <= 3'd2 && f[FLAG_PSTATE])     e = mk(PH_PLEN, 32'd4);
        else if (k <= 3'd3 && f[FLAG_SERIAL])     e = mk(PH_SERIAL, 32'd2);
        else if (k <= 3'd4 && f[FLAG_TS])         e = mk(PH_TS, 32'd8);
        else                                      e = mk(PH_DONE, 32'd0);
        return e;
    endfunction

    // A name length opens a pair when names are present, else a value length.
    function automatic enter_t start_pair(input logic [6:0] f);
        enter_t e;
        if (f[FLAG_NAMES]) e = mk(PH_NLEN, 32'd2);
        else               e = mk(PH_VLEN, 32'd4);
        return e;
    endfunction

    // Next state and result for the byte in the input register.
    always_comb
    begin
        kind_next = start_reg ? in_item.request_kind : kind_reg;
        if (start_reg)
        begin
            ph       = (in_item.request_kind == KIND_EXECUTE) ? PH_IDLEN : PH_QLEN;
            left_cur = (in_item.request_kind == KIND_EXECUTE) ? 32'd2 : 32'd4;
            acc_cur  = 32'd0;
        end
        else
        begin
            ph       = phase_reg;
            left_cur = left_reg;
            acc_cur  = acc_reg;
        end

        acc_sh    = {acc_cur[23:0], in_item.data_byte};
        left_dec  = (left_cur != 32'd0) ? 32'(left_cur - 32'd1) : 32'd0;
        vals_dec  = 16'(vals_reg - 16'd1);
        vcount    = acc_sh[15:0];
        new_flags = in_item.data_byte[6:0];

        phase_next = ph;
        left_next  = left_cur;
        acc_next   = acc_cur;
        flags_next = flags_reg;
        vals_next  = vals_reg;
        err_next   = err_reg;
        start_next = 1'b0;
        ent        = mk(PH_DONE, 32'd0);
        do_enter   = 1'b0;

        res.field_code   = CODE_IGNORED;
        res.field_byte   = in_item.data_byte;
        res.field_last   = 1'b0;
        res.frame_done   = in_item.body_end;
        res.frame_status = ST_OK;

        if (ph == PH_DONE)
        begin
            // Bytes after a complete parse are trailing.
            if (err_reg != ST_BADLEN)
            begin
                err_next = ST_TRAIL;
            end
        end
        else if (ph != PH_ERR)
        begin
            res.field_code = 5'(ph);
            acc_next       = acc_sh;
            left_next      = left_dec;
            if (left_dec == 32'd0)
            begin
                res.field_last = 1'b1;
                do_enter       = 1'b1;
                unique case (ph)
                    PH_QLEN, PH_QUERY:
                    begin
                        if (ph == PH_QLEN && !acc_sh[31] && acc_sh != 32'd0)
                            ent = mk(PH_QUERY, acc_sh);
                        else if (kind_next == KIND_PREPARE)
                            ent = mk(PH_DONE, 32'd0);
                        else
                            ent = mk(PH_CONS, 32'd2);
                    end
                    PH_IDLEN:
                    begin
                        if (acc_sh[15:0] != 16'd0) ent = mk(PH_ID, {16'd0, acc_sh[15:0]});
                        else                       ent = mk(PH_CONS, 32'd2);
                    end
                    PH_ID:    ent = mk(PH_CONS, 32'd2);
                    PH_CONS:  ent = mk(PH_FLAGS, 32'd1);
                    PH_FLAGS:
                    begin
                        flags_next = new_flags;
                        ent        = advance_opt(3'd0, new_flags);
                    end
                    PH_VCOUNT:
                    begin
                        vals_next = vcount;
                        if (vcount == 16'd0) ent = advance_opt(3'd1, flags_reg);
                        else                 ent = start_pair(flags_reg);
                    end
                    PH_NLEN:
                    begin
                        if (acc_sh[15:0] != 16'd0) ent = mk(PH_NAME, {16'd0, acc_sh[15:0]});
                        else                       ent = mk(PH_VLEN, 32'd4);
                    end
                    PH_NAME:  ent = mk(PH_VLEN, 32'd4);
                    PH_VLEN, PH_VALUE:
                    begin
                        if (ph == PH_VLEN && acc_sh[31] && acc_sh != 32'hFFFF_FFFF
                            && acc_sh != 32'hFFFF_FFFE)
                        begin
                            // Length below not-set: the rest of the body is ignored.
                            err_next = ST_BADLEN;
                            ent      = mk(PH_ERR, 32'd0);
                        end
                        else if (ph == PH_VLEN && !acc_sh[31] && acc_sh != 32'd0)
                        begin
                            ent = mk(PH_VALUE, acc_sh);
                        end
                        else
                        begin
                            // Value finished, or null, not set or empty.
                            vals_next = vals_dec;
                            if (vals_dec != 16'd0) ent = start_pair(flags_reg);
                            else                   ent = advance_opt(3'd1, flags_reg);
                        end
                    end
                    PH_PAGE:  ent = advance_opt(3'd2, flags_reg);
                    PH_PLEN:
                    begin
                        if (!acc_sh[31] && acc_sh != 32'd0) ent = mk(PH_PSTATE, acc_sh);
                        else                                ent = advance_opt(3'd3, flags_reg);
                    end
                    PH_PSTATE: ent = advance_opt(3'd3, flags_reg);
                    PH_SERIAL: ent = advance_opt(3'd4, flags_reg);
                    default:   ent = mk(PH_DONE, 32'd0);
                endcase
            end
        end

        if (do_enter)
        begin
            phase_next = ent.ph;
            left_next  = ent.cnt;
            acc_next   = 32'd0;
        end

        // Frame end: report status and return to the body-start state.
        if (in_item.body_end)
        begin
            priority if (err_next == ST_BADLEN) res.frame_status = ST_BADLEN;
            else if (err_next == ST_TRAIL)      res.frame_status = ST_TRAIL;
            else if (phase_next == PH_DONE)     res.frame_status = ST_OK;
            else                                res.frame_status = ST_TRUNC;
            phase_next = PH_QLEN;
            left_next  = 32'd0;
            acc_next   = 32'd0;
            flags_next = 7'd0;
            vals_next  = 16'd0;
            err_next   = ST_OK;
            start_next = 1'b1;
            kind_next  = KIND_QUERY;
        end
    end

    // Phase register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_QLEN;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
        end
    end

    // Counters, accumulator and per-frame flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= 32'd0;
            acc_reg   <= 32'd0;
            flags_reg <= 7'd0;
            vals_reg  <= 16'd0;
            err_reg   <= ST_OK;
            start_reg <= 1'b1;
            kind_reg  <= KIND_QUERY;
        end
        else if (step)
        begin
            left_reg  <= left_next;
            acc_reg   <= acc_next;
            flags_reg <= flags_next;
            vals_reg  <= vals_next;
            err_reg   <= err_next;
            start_reg <= start_next;
            kind_reg  <= kind_next;
        end
    end

    // Checks on the parse state.
    `QRBP_ASSERT_NEXT(a_end_restarts, step && in_item.body_end, start_reg, "frame end did not restart")
    `QRBP_ASSERT_IMPL(a_last_tagged, step && res.field_last, res.field_code != CODE_IGNORED, "last flag on ignored byte")
    `QRBP_ASSERT_IMPL(a_err_phase, phase_reg == PH_ERR, err_reg == ST_BADLEN, "error phase without error")
    `QRBP_ASSERT_IMPL(a_start_clean, start_reg, phase_reg == PH_QLEN && err_reg == ST_OK, "body start not clean")
    `QRBP_ASSERT_NEXT(a_err_sticky, err_reg == ST_BADLEN && !(step && in_item.body_end), err_reg == ST_BADLEN, "error cleared mid frame")

endmodule

// ----- hw/rtl/qrbp_out_stage.sv -----
// Result register stage of the query request body parser.
module qrbp_out_stage
    import qrbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t res,
    output logic      load_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      valid_reg;
    out_item_t item_reg;

    // A new result may enter when the register is empty or being taken.
    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= res;
        end
    end

endmodule

// ----- hw/rtl/query_request_body_parser_core.sv -----
// Top level of the query request body parser: byte stream in, tagged bytes out.
//
// Usage:
//   The slave channel takes one body byte per transaction: s_tdata carries the
//   byte, s_tlast marks the final byte of the body, and s_tuser carries the
//   request kind, sampled on the first byte of each body (query, prepare or
//   execute). The master channel gives exactly one transaction per input byte:
//   m_tuser holds the field code, m_tdata the byte, its field-last flag and the
//   frame status, and m_tlast marks the result of the final body byte.
//   A byte accepted on the slave side is held in the input register, then
//   passes through the parse logic into the result register, which drives
//   the master side. Throughput is one byte per cycle while the receiver
//   does not stall, set by the single phase update per byte between those
//   two registers. Reset clears both stage registers and returns the parser
//   to the start of a body. When the receiver stalls, the result register
//   holds its transaction, the input register takes one more byte only if
//   empty, and s_tready stays low while it is full until m_tready returns.
module query_request_body_parser_core
    import qrbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // body_end
    input  logic [1:0]  s_tuser,   // [1:0] request_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] field_byte, [8] field_last, [10:9] frame_status
    output logic        m_tlast,   // frame_done
    output logic [4:0]  m_tuser    // [4:0] field_code
);

    in_item_t  in_item;
    in_item_t  held_item;
    logic      held_valid;
    logic      load_ready;
    logic      step;
    out_item_t res;
    out_item_t out_item;

    assign in_item.data_byte    = s_tdata;
    assign in_item.body_end     = s_tlast;
    assign in_item.request_kind = s_tuser;

    // One parse step per byte moved from the input to the result register.
    assign step = held_valid && load_ready;

    qrbp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (load_ready),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    qrbp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_item (held_item),
        .res     (res)
    );

    qrbp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .res        (res),
        .load_ready (load_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item)
    );

    // Master-side packing.
    assign m_tdata = {5'd0, out_item.frame_status, out_item.field_last, out_item.field_byte};
    assign m_tlast = out_item.frame_done;
    assign m_tuser = out_item.field_code;

endmodule

// ----- sim/query_request_body_parser_core_test.sv -----
// Self-checking testbench for the query request body parser core.
`timescale 1ns / 100ps

module query_request_body_parser_core_test
    import qrbp_pkg::*;
();

    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_BYTES  = 1400;
    localparam int STALL_BYTES   = 200;
    localparam int STREAM_BYTES  = 300;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tlast;   // body_end
    logic [1:0]  s_tuser;   // [1:0] request_kind
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] field_byte, [8] field_last, [10:9] frame_status
    logic        m_tlast;   // frame_done
    logic [4:0]  m_tuser;   // [4:0] field_code

    // Parser state as the testbench tracks it.
    phase_t      ph_now;
    logic [31:0] field_remaining;
    logic [31:0] len_shift;
    logic [6:0]  opt_flags;
    logic [15:0] pairs_left;
    logic [1:0]  sticky_status;
    logic        new_body;
    logic [1:0]  body_kind;

    // Tagged bytes still to come, oldest first, and the body being built.
    out_item_t   tagged_q[$];
    out_item_t   head_tag;
    logic [7:0]  body_q[$];

    // Run bookkeeping.
    int          error_count = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    int          tags_checked = 0;
    int          quiet_cycles = 0;
    int          endings[4] = '{0, 0, 0, 0};
    logic        src_idle_on = 1'b0;
    logic        sink_idle_on = 1'b0;
    logic        hold_request = 1'b0;

    query_request_body_parser_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    function automatic void restart_body();
        ph_now          = PH_QLEN;
        field_remaining = '0;
        len_shift       = '0;
        opt_flags       = '0;
        pairs_left      = '0;
        sticky_status   = ST_OK;
        new_body        = 1'b1;
        body_kind       = KIND_QUERY;
    endfunction

    function automatic void enter_phase(input phase_t p, input logic [31:0] n);
        ph_now          = p;
        field_remaining = n;
        len_shift       = '0;
    endfunction

    // Move to the first optional part at or after position k that its flag enables.
    function automatic void next_optional(input int k);
        if (k <= 0 && opt_flags[FLAG_VLIST])
            enter_phase(PH_VCOUNT, 2);
        else if (k <= 1 && opt_flags[FLAG_PAGE])
            enter_phase(PH_PAGE, 4);
        else if (k <= 2 && opt_flags[FLAG_PSTATE])
            enter_phase(PH_PLEN, 4);
        else if (k <= 3 && opt_flags[FLAG_SERIAL])
            enter_phase(PH_SERIAL, 2);
        else if (k <= 4 && opt_flags[FLAG_TS])
            enter_phase(PH_TS, 8);
        else
            enter_phase(PH_DONE, 0);
    endfunction

    function automatic void begin_pair();
        if (opt_flags[FLAG_NAMES])
            enter_phase(PH_NLEN, 2);
        else
            enter_phase(PH_VLEN, 4);
    endfunction

    function automatic void finish_value();
        pairs_left = pairs_left - 16'd1;
        if (pairs_left != 0)
            begin_pair();
        else
            next_optional(1);
    endfunction

    function automatic void after_query_text();
        if (body_kind == KIND_PREPARE)
            enter_phase(PH_DONE, 0);
        else
            enter_phase(PH_CONS, 2);
    endfunction

    // Tag one accepted body byte and advance the tracked parser state.
    function automatic out_item_t tag_body_byte(input logic [7:0] b, input logic is_end,
                                                input logic [1:0] kind);
        out_item_t   r;
        phase_t      cur;
        logic [31:0] acc;
        r            = '0;
        r.field_code = CODE_IGNORED;
        r.field_byte = b;
        r.frame_done = is_end;

        // The kind is sampled on the first byte of each body.
        if (new_body)
        begin
            body_kind = kind;
            new_body  = 1'b0;
            if (kind == KIND_EXECUTE)
                enter_phase(PH_IDLEN, 2);
            else
                enter_phase(PH_QLEN, 4);
        end

        if (ph_now == PH_DONE)
        begin
            if (sticky_status != ST_BADLEN)
                sticky_status = ST_TRAIL;
        end
        else if (ph_now < PH_DONE)
        begin
            cur          = ph_now;
            r.field_code = cur;
            len_shift    = {len_shift[23:0], b};
            if (field_remaining != 0)
                field_remaining = field_remaining - 1;
            if (field_remaining == 0)
            begin
                r.field_last = 1'b1;
                acc = len_shift;
                case (cur)
                    PH_QLEN:
                        if (acc[31] || acc == 0)
                            after_query_text();
                        else
                            enter_phase(PH_QUERY, acc);
                    PH_QUERY:
                        after_query_text();
                    PH_IDLEN:
                        if (acc[15:0] != 0)
                            enter_phase(PH_ID, {16'd0, acc[15:0]});
                        else
                            enter_phase(PH_CONS, 2);
                    PH_ID:
                        enter_phase(PH_CONS, 2);
                    PH_CONS:
                        enter_phase(PH_FLAGS, 1);
                    PH_FLAGS:
                    begin
                        opt_flags = b[6:0];
                        next_optional(0);
                    end
                    PH_VCOUNT:
                    begin
                        pairs_left = acc[15:0];
                        if (pairs_left == 0)
                            next_optional(1);
                        else
                            begin_pair();
                    end
                    PH_NLEN:
                        if (acc[15:0] != 0)
                            enter_phase(PH_NAME, {16'd0, acc[15:0]});
                        else
                            enter_phase(PH_VLEN, 4);
                    PH_NAME:
                        enter_phase(PH_VLEN, 4);
                    PH_VLEN:
                        // Null, not set and empty values carry no bytes.
                        if (acc == 32'hFFFF_FFFF || acc == 32'hFFFF_FFFE || acc == 0)
                            finish_value();
                        else if (acc[31])
                        begin
                            sticky_status = ST_BADLEN;
                            enter_phase(PH_ERR, 0);
                        end
                        else
                            enter_phase(PH_VALUE, acc);
                    PH_VALUE:
                        finish_value();
                    PH_PAGE:
                        next_optional(2);
                    PH_PLEN:
                        if (acc[31] || acc == 0)
                            next_optional(3);
                        else
                            enter_phase(PH_PSTATE, acc);
                    PH_PSTATE:
                        next_optional(3);
                    PH_SERIAL:
                        next_optional(4);
                    default:
                        enter_phase(PH_DONE, 0);
                endcase
            end
        end

        // A bad value length outranks trailing bytes and truncation.
        if (is_end)
        begin
            if (sticky_status == ST_BADLEN)
                r.frame_status = ST_BADLEN;
            else if (sticky_status == ST_TRAIL)
                r.frame_status = ST_TRAIL;
            else if (ph_now == PH_DONE)
                r.frame_status = ST_OK;
            else
                r.frame_status = ST_TRUNC;
            restart_body();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Body construction
    // ------------------------------------------------------------------

    // Append the low n bytes of v, most significant first.
    function automatic void put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            body_q.insert(body_q.size(), v[8*i +: 8]);
    endfunction

    function automatic void put_random(input int n);
        for (int i = 0; i < n; i++)
            body_q.insert(body_q.size(), 8'($urandom_range(0, 255)));
    endfunction

    // A length word that is usually short, sometimes zero and sometimes negative.
    function automatic logic [31:0] pick_length();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 32'h8000_0000 | $urandom;
        else if (sel == 1)
            return 32'd0;
        else
            return $urandom_range(1, 6);
    endfunction

    // Build a body with random content for the given kind; with allow_bad set, a value length may be invalid.
    task automatic build_random_body(input logic [1:0] kind, input logic allow_bad);
        logic [31:0] len;
        logic [7:0]  flags_b;
        int          count;
        int          sel;
        body_q.delete();
        if (kind == KIND_EXECUTE)
        begin
            len = $urandom_range(0, 4);
            put_be(len, 2);
            put_random(len);
        end
        else
        begin
            len = pick_length();
            put_be(len, 4);
            if (!len[31])
                put_random(len);
        end
        if (kind != KIND_PREPARE)
        begin
            put_random(2);
            flags_b = 8'($urandom_range(0, 255));
            body_q.insert(body_q.size(), flags_b);
            if (flags_b[FLAG_VLIST])
            begin
                count = $urandom_range(0, 3);
                put_be(count, 2);
                for (int v = 0; v < count; v++)
                begin
                    if (flags_b[FLAG_NAMES])
                    begin
                        len = $urandom_range(0, 3);
                        put_be(len, 2);
                        put_random(len);
                    end
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        len = 32'hFFFF_FFFF;
                    else if (sel == 1)
                        len = 32'hFFFF_FFFE;
                    else if (sel == 2 && allow_bad)
                    begin
                        len = 32'h8000_0000 | $urandom;
                        if (len >= 32'hFFFF_FFFE)
                            len = 32'hFFFF_FFFD;
                    end
                    else
                        len = $urandom_range(0, 5);
                    put_be(len, 4);
                    if (!len[31])
                        put_random(len);
                end
            end
            if (flags_b[FLAG_PAGE])
                put_random(4);
            if (flags_b[FLAG_PSTATE])
            begin
                len = pick_length();
                put_be(len, 4);
                if (!len[31])
                    put_random(len);
            end
            if (flags_b[FLAG_SERIAL])
                put_random(2);
            if (flags_b[FLAG_TS])
                put_random(8);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus side
    // ------------------------------------------------------------------

    // Offer one byte; returns at the clock edge that accepts the transaction.
    task automatic send_byte(input logic [7:0] d, input logic is_end, input logic [1:0] kind);
        logic taken;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= is_end;
        s_tuser  <= kind;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        tagged_q.insert(tagged_q.size(), tag_body_byte(d, is_end, kind));
        bytes_sent++;
    endtask

    // Send the body under construction; only its first byte carries the real kind.
    task automatic send_body(input logic [1:0] kind);
        for (int i = 0; i < body_q.size(); i++)
            send_byte(body_q[i], i == body_q.size() - 1,
                      (i == 0) ? kind : 2'($urandom_range(0, 3)));
        frames_sent++;
    endtask

    // One random frame: mostly well formed, some cut short, padded or pure noise.
    task automatic send_random_frame();
        logic [1:0] kind;
        int         sel;
        int         keep;
        kind = 2'($urandom_range(0, 3));
        sel  = $urandom_range(0, 19);
        if (sel == 0)
        begin
            body_q.delete();
            put_random($urandom_range(1, 12));
        end
        else
        begin
            build_random_body(kind, sel < 5);
            if (sel >= 5 && sel < 8 && body_q.size() > 1)
            begin
                keep = $urandom_range(1, body_q.size() - 1);
                while (body_q.size() > keep)
                    void'(body_q.pop_back());
            end
            else if (sel >= 8 && sel < 11)
                put_random($urandom_range(1, 4));
        end
        send_body(kind);
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Prepare bodies, the unused kind, a negative length, an execute body and a one-byte body.
    task automatic test_short_bodies();
        body_q.delete();
        put_be(0, 4);
        send_body(KIND_PREPARE);
        body_q.delete();
        put_be(2, 4);
        put_be(16'h00FF, 2);
        send_body(KIND_PREPARE);
        // Unused kind parses as a query; the negative length means no text.
        body_q.delete();
        put_be(32'hFFFF_FFFF, 4);
        put_be(16'hFFFF, 2);
        put_be(8'h80, 1);
        send_body(2'd3);
        body_q.delete();
        put_be(0, 2);
        put_be(16'h0001, 2);
        put_be(8'h02, 1);
        send_body(KIND_EXECUTE);
        // A body that ends on its first byte is truncated.
        body_q.delete();
        put_be(8'hFF, 1);
        send_body(KIND_EXECUTE);
    endtask

    // Names, null and not-set values, a zero count and an invalid value length.
    task automatic test_value_list();
        body_q.delete();
        put_be(0, 4);
        put_be(16'h000A, 2);
        put_be(8'h41, 1);
        put_be(3, 2);
        put_be(0, 2);
        put_be(32'hFFFF_FFFF, 4);
        put_be(1, 2);
        put_be(8'h78, 1);
        put_be(32'hFFFF_FFFE, 4);
        put_be(0, 2);
        put_be(1, 4);
        put_be(8'h00, 1);
        send_body(KIND_QUERY);
        body_q.delete();
        put_be(1, 2);
        put_be(8'h5A, 1);
        put_be(16'h0004, 2);
        put_be(8'h01, 1);
        put_be(0, 2);
        send_body(KIND_EXECUTE);
        // Bytes after an invalid value length are ignored; status stays invalid.
        body_q.delete();
        put_be(0, 4);
        put_be(16'h0001, 2);
        put_be(8'h01, 1);
        put_be(1, 2);
        put_be(32'hFFFF_FFFD, 4);
        put_be(16'hA5A5, 2);
        send_body(KIND_QUERY);
    endtask

    // Every optional part at once with a trailing byte, then a cut paging state.
    task automatic test_optional_fields();
        body_q.delete();
        put_be(3, 4);
        put_be(24'h616263, 3);
        put_be(16'h0006, 2);
        put_be(8'hFF, 1);
        put_be(1, 2);
        put_be(1, 2);
        put_be(8'h6E, 1);
        put_be(2, 4);
        put_be(16'hFF00, 2);
        put_be(32'h0000_1388, 4);
        put_be(32'h8000_0000, 4);
        put_be(16'h0008, 2);
        put_be(64'hFFFF_FFFF_FFFF_FFFF, 8);
        put_be(8'h00, 1);
        send_body(KIND_QUERY);
        body_q.delete();
        put_be(0, 4);
        put_be(16'h0001, 2);
        put_be(8'h08, 1);
        put_be(2, 4);
        put_be(8'h11, 1);
        send_body(KIND_QUERY);
    endtask

    // Random frames with idle bursts on both sides.
    task automatic test_random_frames();
        int stop_at;
        stop_at      = bytes_sent + RANDOM_BYTES;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        while (bytes_sent < stop_at)
            send_random_frame();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming.
    task automatic test_output_stall();
        int stop_at;
        stop_at      = bytes_sent + STALL_BYTES;
        src_idle_on  = 1'b0;
        hold_request = 1'b1;
        while (bytes_sent < stop_at)
            send_random_frame();
        while (hold_request)
            @(posedge clk);
    endtask

    // Back-to-back transactions with no idling on either side.
    task automatic test_full_rate();
        int stop_at;
        stop_at      = bytes_sent + STREAM_BYTES;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (bytes_sent < stop_at)
            send_random_frame();
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("MISMATCH at tagged byte %0d: %s", tags_checked, what);
        error_count++;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare each output transaction with the oldest predicted tag.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tagged_q.size() == 0)
                report_mismatch($sformatf("unexpected result, code %0d byte %02h",
                                          m_tuser, m_tdata[7:0]));
            else
            begin
                head_tag = tagged_q.pop_front();
                if (m_tuser !== head_tag.field_code)
                    report_mismatch($sformatf("field_code %0d, expected %0d",
                                              m_tuser, head_tag.field_code));
                if (m_tdata[7:0] !== head_tag.field_byte)
                    report_mismatch($sformatf("field_byte %02h, expected %02h",
                                              m_tdata[7:0], head_tag.field_byte));
                if (m_tdata[8] !== head_tag.field_last)
                    report_mismatch($sformatf("field_last %0b, expected %0b",
                                              m_tdata[8], head_tag.field_last));
                if (m_tlast !== head_tag.frame_done)
                    report_mismatch($sformatf("frame_done %0b, expected %0b",
                                              m_tlast, head_tag.frame_done));
                if (m_tdata[10:9] !== head_tag.frame_status)
                    report_mismatch($sformatf("frame_status %0d, expected %0d",
                                              m_tdata[10:9], head_tag.frame_status));
                if (m_tdata[15:11] !== 5'd0)
                    report_mismatch($sformatf("tdata padding %02h, expected 0",
                                              m_tdata[15:11]));
                if (head_tag.frame_done)
                    endings[head_tag.frame_status]++;
            end
            tags_checked++;
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d tags outstanding",
                     quiet_cycles, tagged_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= '0;
        restart_body();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_bodies();
        test_value_list();
        test_optional_fields();
        test_random_frames();
        test_output_stall();
        test_full_rate();
        s_tvalid <= 1'b0;

        // Drain the pipeline, then keep watching for stray results.
        while (tagged_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d body bytes in %0d frames of all request kinds; %0d tags checked.",
                 bytes_sent, frames_sent, tags_checked);
        $display("Frame endings: ok %0d, truncated %0d, invalid value length %0d, trailing %0d.",
                 endings[ST_OK], endings[ST_TRUNC], endings[ST_BADLEN], endings[ST_TRAIL]);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
